FILE: hdl/pcjc_pkg.sv
// Shared types, register codes and constants for the camera frame capture block.
package pcjc_pkg;

   localparam int ROW_PIXELS_W = 13;
   localparam int ROWS_W       = 12;
   localparam int BPP_W        = 2;
   localparam int CAP_W        = 25;
   localparam int CSR_DATA_W   = 25;
   localparam int CSR_INDEX_W  = 3;
   localparam int BYTE_W       = 8;
   localparam int OFFSET_W     = 24;
   localparam int LENGTH_W     = 25;
   localparam int SEEN_W       = 24;

   // Reset values of the configuration registers
   localparam logic [ROW_PIXELS_W-1:0] ROW_PIXELS_RESET = 13'd320;
   localparam logic [ROWS_W-1:0]       ROWS_RESET       = 12'd240;
   localparam logic [BPP_W-1:0]        BPP_RESET        = 2'd2;
   localparam logic                    GRAY_RESET       = 1'b0;
   localparam logic [CAP_W-1:0]        FIRST_CAP_RESET  = 25'd153600;
   localparam logic [CAP_W-1:0]        SECOND_CAP_RESET = 25'd0;

   // JPEG end-of-image marker bytes
   localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [BYTE_W-1:0] MARKER_EOI    = 8'hD9;

   // Estimate = row_pixels * rows * bytes_per_pixel / 5, divide done as
   // multiply by ceil(2^30 / 5) and shift; exact for products below 2^30.
   localparam int               PROD_W    = 25;
   localparam int               SCALED_W  = 27;
   localparam int               RECIP_W   = 28;
   localparam int               MUL_W     = SCALED_W + RECIP_W;
   localparam int               EST_SHIFT = 30;
   localparam logic [RECIP_W-1:0] EST_RECIP = 28'd214748365;
   localparam int               EST_LAT_W = 3;
   localparam logic [EST_LAT_W-1:0] EST_LAT = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_PIXELS = 3'd0,
      CSR_ROWS       = 3'd1,
      CSR_BPP        = 3'd2,
      CSR_GRAY       = 3'd3,
      CSR_FIRST_CAP  = 3'd4,
      CSR_SECOND_CAP = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_FRAME_START = 1'b0,
      OP_DATA        = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      END_NONE     = 2'd0,
      END_MARKER   = 2'd1,
      END_ROWS     = 2'd2,
      END_OVERFLOW = 2'd3
   } end_type;

   typedef struct packed {
      logic [ROW_PIXELS_W-1:0] row_pixels;
      logic [ROWS_W-1:0]       rows;
      logic [BPP_W-1:0]        bytes_per_pixel;
      logic                    gray_mode;
      logic [CAP_W-1:0]        first_capacity;
      logic [CAP_W-1:0]        second_capacity;
      logic [LENGTH_W-1:0]     estimate;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   pixel_byte;
      logic                is_prefix;
      logic                is_eoi;
   } entry_type;

   typedef struct packed {
      logic                store;
      logic                buffer_select;
      logic [OFFSET_W-1:0] store_offset;
      logic [BYTE_W-1:0]   store_byte;
      logic                frame_done;
      end_type             end_status;
      logic [LENGTH_W-1:0] frame_length;
   } rsp_type;

endpackage

FILE: hdl/pcjc_front.sv
// Front end: configuration registers, frame length estimate, request intake and tagging.
module pcjc_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [pcjc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pcjc_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_operation,
   input  logic [pcjc_pkg::BYTE_W-1:0]             req_pixel_byte,
   output logic                                    q_valid,
   input  logic                                    q_ready,
   output pcjc_pkg::entry_type                     q_entry,
   output pcjc_pkg::cfg_type                       cfg
);
   import pcjc_pkg::*;

   logic [ROW_PIXELS_W-1:0] row_pixels_ff, row_pixels_in;
   logic [ROWS_W-1:0]       rows_ff, rows_in;
   logic [BPP_W-1:0]        bpp_ff, bpp_in;
   logic                    gray_ff, gray_in;
   logic [CAP_W-1:0]        cap1_ff, cap1_in;
   logic [CAP_W-1:0]        cap2_ff, cap2_in;

   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [SCALED_W-1:0]     scaled_ff, scaled_in;
   logic [MUL_W-1:0]        mul_ff, mul_in;
   logic [EST_LAT_W-1:0]    busy_ff, busy_in;

   always_comb begin
      row_pixels_in = row_pixels_ff;
      rows_in       = rows_ff;
      bpp_in        = bpp_ff;
      gray_in       = gray_ff;
      cap1_in       = cap1_ff;
      cap2_in       = cap2_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_PIXELS: row_pixels_in = csr_write_data[ROW_PIXELS_W-1:0];
            CSR_ROWS:       rows_in       = csr_write_data[ROWS_W-1:0];
            CSR_BPP:        bpp_in        = csr_write_data[BPP_W-1:0];
            CSR_GRAY:       gray_in       = csr_write_data[0];
            CSR_FIRST_CAP:  cap1_in       = csr_write_data[CAP_W-1:0];
            CSR_SECOND_CAP: cap2_in       = csr_write_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Estimate pipeline: one multiply per stage
   assign prod_in   = PROD_W'(row_pixels_ff) * PROD_W'(rows_ff);
   assign scaled_in = SCALED_W'(prod_ff) * SCALED_W'(bpp_ff);
   assign mul_in    = MUL_W'(scaled_ff) * MUL_W'(EST_RECIP);

   // Hold off requests until the estimate reflects the latest register write
   always_comb begin
      if (csr_write_enable) begin
         busy_in = EST_LAT;
      end else if (busy_ff != '0) begin
         busy_in = busy_ff - EST_LAT_W'(1);
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pixels_ff <= ROW_PIXELS_RESET;
         rows_ff       <= ROWS_RESET;
         bpp_ff        <= BPP_RESET;
         gray_ff       <= GRAY_RESET;
         cap1_ff       <= FIRST_CAP_RESET;
         cap2_ff       <= SECOND_CAP_RESET;
         busy_ff       <= EST_LAT;
      end else begin
         row_pixels_ff <= row_pixels_in;
         rows_ff       <= rows_in;
         bpp_ff        <= bpp_in;
         gray_ff       <= gray_in;
         cap1_ff       <= cap1_in;
         cap2_ff       <= cap2_in;
         busy_ff       <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      mul_ff    <= mul_in;
   end

   assign cfg.row_pixels      = row_pixels_ff;
   assign cfg.rows            = rows_ff;
   assign cfg.bytes_per_pixel = bpp_ff;
   assign cfg.gray_mode       = gray_ff;
   assign cfg.first_capacity  = cap1_ff;
   assign cfg.second_capacity = cap2_ff;
   assign cfg.estimate        = mul_ff[EST_SHIFT +: LENGTH_W];

   // Tag each request with its kind and the marker byte matches
   assign q_valid            = req_valid && (busy_ff == '0);
   assign req_ready          = q_ready && (busy_ff == '0);
   assign q_entry.op         = op_type'(req_operation);
   assign q_entry.pixel_byte = req_pixel_byte;
   assign q_entry.is_prefix  = (req_pixel_byte == MARKER_PREFIX);
   assign q_entry.is_eoi     = (req_pixel_byte == MARKER_EOI);

endmodule

FILE: hdl/pcjc_queue.sv
// Short request queue between the front end and the capture engine.
module pcjc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pcjc_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output pcjc_pkg::entry_type out_entry
);
   import pcjc_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   entry_type        entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != NW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

FILE: hdl/pcjc_back.sv
// Capture engine: frame state, buffer chaining, end detection and the response register.
module pcjc_back #(
   parameter int MAX_ROW_PIXELS   = 4096,
   parameter int MAX_ROWS         = 2048,
   parameter int MAX_BUFFER_BYTES = 16777216
) (
   input  logic                clock,
   input  logic                reset,
   input  pcjc_pkg::cfg_type   cfg,
   input  logic                q_valid,
   output logic                q_ready,
   input  pcjc_pkg::entry_type q_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pcjc_pkg::rsp_type   rsp
);
   import pcjc_pkg::*;

   localparam int CW  = $clog2(2 * MAX_ROW_PIXELS + 1);
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int SW  = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int RBW = (CW > ROW_PIXELS_W + BPP_W) ? CW : ROW_PIXELS_W + BPP_W;
   localparam int RLW = (RW > ROWS_W) ? RW : ROWS_W;
   localparam int CPW = (SW > CAP_W) ? SW : CAP_W;

   function automatic logic [SW-1:0] clamp_cap(input logic [CAP_W-1:0] c);
      logic [CPW-1:0] e;
      e = CPW'(c);
      return (e > CPW'(MAX_BUFFER_BYTES)) ? SW'(MAX_BUFFER_BYTES) : SW'(e);
   endfunction

   // Geometry and capacities after clamping, registered off the config
   logic [RBW-1:0]      rb_full;
   logic [RLW-1:0]      rl_full;
   logic [CW-1:0]       rowb_ff, rowb_in;
   logic [RW-1:0]       rlim_ff, rlim_in;
   logic [SW-1:0]       cap1_ff, cap2_ff;
   logic                gray_ff, empty_ff;
   logic [LENGTH_W-1:0] est_ff;

   assign rb_full = RBW'(cfg.row_pixels) * RBW'(cfg.bytes_per_pixel);
   assign rl_full = RLW'(cfg.rows);
   assign rowb_in = (rb_full > RBW'(2 * MAX_ROW_PIXELS)) ? CW'(2 * MAX_ROW_PIXELS) : CW'(rb_full);
   assign rlim_in = (rl_full > RLW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rl_full);

   always_ff @(posedge clock) begin
      rowb_ff  <= rowb_in;
      rlim_ff  <= rlim_in;
      cap1_ff  <= clamp_cap(cfg.first_capacity);
      cap2_ff  <= clamp_cap(cfg.second_capacity);
      gray_ff  <= cfg.gray_mode;
      empty_ff <= (rowb_in == '0) || (rlim_in == '0);
      est_ff   <= cfg.estimate;
   end

   // Frame state
   logic                armed_ff, armed_in;
   logic                second_ff, second_in;
   logic [SW-1:0]       space_ff, space_in;
   logic [OFFSET_W-1:0] woff_ff, woff_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                prev_prefix_ff, prev_prefix_in;
   logic [SEEN_W-1:0]   seen_ff, seen_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                fire;
   logic                halt;
   logic [CW-1:0]       col_inc;
   logic [RW-1:0]       row_inc;
   rsp_type             r;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign fire    = q_valid && q_ready;
   assign col_inc = col_ff + CW'(1);
   assign row_inc = row_ff + RW'(1);

   always_comb begin
      armed_in       = armed_ff;
      second_in      = second_ff;
      space_in       = space_ff;
      woff_in        = woff_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      prev_prefix_in = prev_prefix_ff;
      seen_in        = seen_ff;
      halt           = 1'b0;
      r              = '0;
      if (fire) begin
         if (q_entry.op == OP_FRAME_START) begin
            armed_in       = 1'b1;
            second_in      = 1'b0;
            space_in       = cap1_ff;
            woff_in        = '0;
            col_in         = '0;
            row_in         = '0;
            prev_prefix_in = 1'b0;
            seen_in        = '0;
            if (empty_ff) begin
               armed_in       = 1'b0;
               r.frame_done   = 1'b1;
               r.end_status   = END_ROWS;
               r.frame_length = est_ff;
            end
         end else if (armed_ff) begin
            if (!gray_ff || !col_ff[0]) begin
               r.store         = 1'b1;
               r.buffer_select = second_ff;
               r.store_offset  = woff_ff;
               r.store_byte    = q_entry.pixel_byte;
               woff_in         = woff_ff + OFFSET_W'(1);
               if (space_ff > SW'(1)) begin
                  space_in = space_ff - SW'(1);
               end else if (!second_ff && (cap2_ff != '0)) begin
                  // chain into the second buffer
                  second_in = 1'b1;
                  space_in  = cap2_ff;
                  woff_in   = '0;
               end else begin
                  space_in       = '0;
                  armed_in       = 1'b0;
                  halt           = 1'b1;
                  r.frame_done   = 1'b1;
                  r.end_status   = END_OVERFLOW;
                  r.frame_length = est_ff;
               end
            end
            if (!halt) begin
               if (prev_prefix_ff && q_entry.is_eoi) begin
                  armed_in       = 1'b0;
                  r.frame_done   = 1'b1;
                  r.end_status   = END_MARKER;
                  r.frame_length = LENGTH_W'(seen_ff) + LENGTH_W'(1);
               end else begin
                  prev_prefix_in = q_entry.is_prefix;
                  if (seen_ff != '1) begin
                     seen_in = seen_ff + SEEN_W'(1);
                  end
                  if (col_inc >= rowb_ff) begin
                     col_in = '0;
                     row_in = row_inc;
                     if (row_inc >= rlim_ff) begin
                        armed_in       = 1'b0;
                        r.frame_done   = 1'b1;
                        r.end_status   = END_ROWS;
                        r.frame_length = est_ff;
                     end
                  end else begin
                     col_in = col_inc;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_in = fire ? r : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         second_ff      <= 1'b0;
         space_ff       <= '0;
         woff_ff        <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         prev_prefix_ff <= 1'b0;
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         armed_ff       <= armed_in;
         second_ff      <= second_in;
         space_ff       <= space_in;
         woff_ff        <= woff_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         prev_prefix_ff <= prev_prefix_in;
         seen_ff        <= seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: hdl/parallel_camera_jpeg_capture.sv
// Top level of the camera frame capture block: front end, request queue, capture engine.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_operation, req_pixel_byte
//   rsp      out        rsp_valid / rsp_ready   rsp_store ... rsp_frame_length
//   csr      in         csr_write_enable        csr_index, csr_write_data
//
// One request per cycle sustained while responses are taken and the estimate is settled;
// each request goes through a queue slot, then the engine, into the response register.
// Reset and every register write hold req_ready low for four cycles while the
// frame length estimate pipeline (three multiply stages) settles.
// A stalled response stops the engine; the queue keeps taking requests until full.
module parallel_camera_jpeg_capture #(
   parameter int MAX_ROW_PIXELS   = 4096,
   parameter int MAX_ROWS         = 2048,
   parameter int MAX_BUFFER_BYTES = 16777216,
   parameter int QUEUE_DEPTH      = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [pcjc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcjc_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic [pcjc_pkg::BYTE_W-1:0]        req_pixel_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_store,
   output logic                               rsp_buffer_select,
   output logic [pcjc_pkg::OFFSET_W-1:0]      rsp_store_offset,
   output logic [pcjc_pkg::BYTE_W-1:0]        rsp_store_byte,
   output logic                               rsp_frame_done,
   output logic [1:0]                         rsp_end_status,
   output logic [pcjc_pkg::LENGTH_W-1:0]      rsp_frame_length
);
   import pcjc_pkg::*;

   cfg_type   cfg;
   entry_type push_entry, pop_entry;
   logic      push_valid, push_ready;
   logic      pop_valid, pop_ready;
   rsp_type   rsp;

   pcjc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_pixel_byte   (req_pixel_byte),
      .q_valid          (push_valid),
      .q_ready          (push_ready),
      .q_entry          (push_entry),
      .cfg              (cfg)
   );

   pcjc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   pcjc_back #(
      .MAX_ROW_PIXELS   (MAX_ROW_PIXELS),
      .MAX_ROWS         (MAX_ROWS),
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (pop_valid),
      .q_ready   (pop_ready),
      .q_entry   (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_store         = rsp.store;
   assign rsp_buffer_select = rsp.buffer_select;
   assign rsp_store_offset  = rsp.store_offset;
   assign rsp_store_byte    = rsp.store_byte;
   assign rsp_frame_done    = rsp.frame_done;
   assign rsp_end_status    = rsp.end_status;
   assign rsp_frame_length  = rsp.frame_length;

endmodule
